// ----- hdl/rag_pkg.sv -----
package rag_pkg;

	localparam int MaxProcesses = 32;
	localparam int MaxResources = 32;
	localparam int NodeSlots = MaxProcesses + MaxResources;
	localparam int SlotW = $clog2(NodeSlots);
	localparam int CountW = 6;
	localparam int CountLimit = 32;
	localparam int DepthW = SlotW + 1;
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DETECT = 2'd2,
		CMD_NONE   = 2'd3
	} command_t;

	typedef enum logic [0:0] {
		REG_NUM_PROCESSES = 1'b0,
		REG_NUM_RESOURCES = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_DETECT = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SlotW-1:0] row;
		logic [SlotW-1:0] col;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ADD,
		ST_ROOT,
		ST_SCAN,
		ST_FIND,
		ST_EMIT,
		ST_EMIT_WAIT,
		ST_POP,
		ST_RESUME,
		ST_NONE
	} state_t;

	function automatic logic [CountW-1:0] saturate_count(input logic [CountW-1:0] v,
			input int cap);
		logic [CountW-1:0] lim;
		lim = (cap < CountLimit) ? CountW'(cap) : CountW'(CountLimit);
		if (v == '0) begin
			return CountW'(1);
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

endpackage

// ----- hdl/rag_front.sv -----
module rag_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	output logic                      stall,
	input  logic [1:0]                command,
	input  logic                      edge_kind,
	input  logic [4:0]                from_number,
	input  logic [4:0]                to_number,
	input  logic [rag_pkg::CountW-1:0] num_processes,
	input  logic [rag_pkg::CountW-1:0] num_resources,
	output logic                      job_valid,
	input  logic                      job_ready,
	output rag_pkg::job_t             job
);
	import rag_pkg::*;

	job_t queue_q [QueueDepth];
	logic [$clog2(QueueDepth+1)-1:0] count_q;
	logic wr_ptr_q, rd_ptr_q;
	logic accept, push, pop;
	logic [4:0] p_num, r_num;
	job_t in_job;
	logic keep;

	assign stall = (count_q == ($clog2(QueueDepth+1))'(QueueDepth));
	assign accept = valid && !stall;
	assign p_num = edge_kind ? to_number : from_number;
	assign r_num = edge_kind ? from_number : to_number;

	always_comb begin
		in_job = '0;
		keep = 1'b0;
		case (command_t'(command))
			CMD_CLEAR: begin
				in_job.op = OP_CLEAR;
				keep = 1'b1;
			end
			CMD_ADD: begin
				in_job.op = OP_ADD;
				keep = ({1'b0, p_num} < num_processes) && ({1'b0, r_num} < num_resources);
				if (edge_kind) begin
					in_job.row = SlotW'(MaxProcesses) + SlotW'(r_num);
					in_job.col = SlotW'(p_num);
				end else begin
					in_job.row = SlotW'(p_num);
					in_job.col = SlotW'(MaxProcesses) + SlotW'(r_num);
				end
			end
			CMD_DETECT: begin
				in_job.op = OP_DETECT;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = accept && keep;
	assign job_valid = (count_q != '0);
	assign pop = job_valid && job_ready;
	assign job = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == ($clog2(QueueDepth+1))'(QueueDepth) |-> !push)
		else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ($clog2(QueueDepth+1))'(QueueDepth))
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

// ----- hdl/rag_back.sv -----
module rag_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  rag_pkg::job_t             job,
	input  logic [rag_pkg::CountW-1:0] num_processes,
	input  logic [rag_pkg::CountW-1:0] num_resources,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      deadlock,
	output logic                      node_is_resource,
	output logic [4:0]                node_number,
	output logic                      last
);
	import rag_pkg::*;

	// Edge rows live in a memory; a row of valid bits stands in for clearing it.
	logic [NodeSlots-1:0] matrix_mem [NodeSlots];
	logic [NodeSlots-1:0] row_valid_q;
	logic [NodeSlots-1:0] row_rd_q;
	logic [SlotW-1:0]     stack_node_mem [NodeSlots];
	logic [DepthW-1:0]    stack_next_mem [NodeSlots];

	state_t state_q, state_d;
	logic [NodeSlots-1:0] visited_q, on_stack_q;
	logic [DepthW-1:0]    depth_q;
	logic [SlotW:0]       root_q;
	logic [DepthW-1:0]    scan_q;
	logic [SlotW-1:0]     v_q;
	logic [SlotW-1:0]     target_q;
	logic [DepthW-1:0]    emit_k_q;
	logic                 emit_on_q;
	logic [SlotW-1:0]     rd_node_q;
	logic [DepthW-1:0]    rd_next_q;
	logic [SlotW-1:0]     top;
	logic [NodeSlots-1:0] in_use, row_eff, cand;
	logic                 cand_any;
	logic [SlotW-1:0]     cand_idx;
	logic                 out_full_q;
	logic                 out_load;

	assign top = depth_q[SlotW-1:0] - 1'b1;

	always_comb begin
		for (int i = 0; i < NodeSlots; i++) begin
			if (i < MaxProcesses) in_use[i] = (CountW'(i) < num_processes);
			else in_use[i] = (CountW'(i - MaxProcesses) < num_resources);
		end
	end

	always_comb begin
		row_eff = row_valid_q[v_q] ? row_rd_q : '0;
		for (int i = 0; i < NodeSlots; i++) begin
			cand[i] = row_eff[i] && in_use[i] && (DepthW'(i) >= scan_q)
				&& (on_stack_q[i] || !visited_q[i]);
		end
		cand_any = |cand;
		cand_idx = '0;
		for (int i = NodeSlots - 1; i >= 0; i--) begin
			if (cand[i]) cand_idx = SlotW'(i);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (job_valid) begin
					case (job.op)
						OP_ADD: state_d = ST_ADD;
						OP_DETECT: state_d = ST_ROOT;
						default: state_d = ST_IDLE;
					endcase
				end
			ST_ADD: state_d = ST_IDLE;
			ST_ROOT:
				if (root_q >= (SlotW+1)'(num_processes) || root_q >= (SlotW+1)'(MaxProcesses))
					state_d = ST_NONE;
				else if (visited_q[root_q[SlotW-1:0]]) state_d = ST_ROOT;
				else state_d = ST_SCAN;
			ST_SCAN: state_d = ST_FIND;
			ST_FIND:
				if (cand_any && on_stack_q[cand_idx]) state_d = ST_EMIT;
				else if (cand_any && depth_q < DepthW'(NodeSlots)) state_d = ST_SCAN;
				else state_d = ST_POP;
			ST_POP: state_d = (depth_q == '0) ? ST_ROOT : ST_RESUME;
			ST_RESUME: state_d = ST_SCAN;
			ST_EMIT: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT:
				if (!out_full_q || !out_stall) begin
					if (emit_k_q == depth_q) state_d = ST_IDLE;
					else state_d = ST_EMIT;
				end
			ST_NONE:
				if (!out_full_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == ST_IDLE);
	end

	assign out_load = (!out_full_q || !out_stall) && ((state_q == ST_NONE)
		|| (state_q == ST_EMIT_WAIT && (emit_on_q || rd_node_q == target_q)));

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			matrix_mem[v_q] <= (row_valid_q[v_q] ? row_rd_q : '0)
				| (NodeSlots'(1) << target_q);
		end
		row_rd_q <= matrix_mem[state_q == ST_IDLE ? job.row : v_q];
		if (state_q == ST_EMIT) rd_node_q <= stack_node_mem[emit_k_q[SlotW-1:0]];
		else if (state_q == ST_POP) rd_node_q <= stack_node_mem[top];
		rd_next_q <= stack_next_mem[top];
		if (state_q == ST_ROOT) begin
			stack_node_mem[0] <= root_q[SlotW-1:0];
			stack_next_mem[0] <= '0;
		end else if (state_q == ST_FIND && cand_any && !on_stack_q[cand_idx]
				&& depth_q < DepthW'(NodeSlots)) begin
			stack_next_mem[top] <= DepthW'(cand_idx) + 1'b1;
			stack_node_mem[depth_q[SlotW-1:0]] <= cand_idx;
			stack_next_mem[depth_q[SlotW-1:0]] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_valid_q <= '0;
			visited_q <= '0;
			on_stack_q <= '0;
			depth_q <= '0;
			root_q <= '0;
			scan_q <= '0;
			v_q <= '0;
			target_q <= '0;
			emit_k_q <= '0;
			emit_on_q <= 1'b0;
			out_full_q <= 1'b0;
			deadlock <= 1'b0;
			node_is_resource <= 1'b0;
			node_number <= '0;
			last <= 1'b0;
		end else begin
			state_q <= state_d;
			out_full_q <= out_load || (out_full_q && out_stall);
			case (state_q)
				ST_IDLE:
					if (job_valid) begin
						case (job.op)
							OP_CLEAR: row_valid_q <= '0;
							OP_ADD: begin
								v_q <= job.row;
								target_q <= job.col;
							end
							default: begin
								visited_q <= '0;
								on_stack_q <= '0;
								depth_q <= '0;
								root_q <= '0;
							end
						endcase
					end
				ST_ADD: row_valid_q[v_q] <= 1'b1;
				ST_ROOT:
					if (!(root_q >= (SlotW+1)'(num_processes) || root_q >= (SlotW+1)'(MaxProcesses))) begin
						if (visited_q[root_q[SlotW-1:0]]) begin
							root_q <= root_q + 1'b1;
						end else begin
							visited_q[root_q[SlotW-1:0]] <= 1'b1;
							on_stack_q[root_q[SlotW-1:0]] <= 1'b1;
							depth_q <= DepthW'(1);
							v_q <= root_q[SlotW-1:0];
							scan_q <= '0;
							root_q <= root_q + 1'b1;
						end
					end
				ST_FIND:
					if (cand_any && on_stack_q[cand_idx]) begin
						target_q <= cand_idx;
						emit_k_q <= '0;
						emit_on_q <= 1'b0;
					end else if (cand_any && depth_q < DepthW'(NodeSlots)) begin
						visited_q[cand_idx] <= 1'b1;
						on_stack_q[cand_idx] <= 1'b1;
						depth_q <= depth_q + 1'b1;
						v_q <= cand_idx;
						scan_q <= '0;
					end else begin
						on_stack_q[v_q] <= 1'b0;
						depth_q <= depth_q - 1'b1;
					end
				ST_RESUME: begin
					v_q <= rd_node_q;
					scan_q <= rd_next_q;
				end
				ST_EMIT: emit_k_q <= emit_k_q + 1'b1;
				ST_EMIT_WAIT:
					if (out_load) begin
						emit_on_q <= 1'b1;
						deadlock <= 1'b1;
						node_is_resource <= (rd_node_q >= SlotW'(MaxProcesses));
						node_number <= 5'(rd_node_q);
						last <= (emit_k_q == depth_q);
					end
				ST_NONE:
					if (out_load) begin
						deadlock <= 1'b0;
						node_is_resource <= 1'b0;
						node_number <= '0;
						last <= 1'b1;
					end
				default: ;
			endcase
		end
	end

	assign out_valid = out_full_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DepthW'(NodeSlots))
		else $error("stack depth beyond node count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_full_q && out_stall |=> out_full_q && $stable(node_number))
		else $error("result lost under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !job_ready)
		else $error("job taken while busy");

endmodule

// ----- hdl/rag_deadlock_cycle_detector.sv -----
// Keeps a process/resource allocation graph and searches it depth-first for a cycle.
// A clear beat is handled in the idle state; an add beat also passes the add state, since
// the edge row is read before it is written back. A detect beat tries each root in the
// root state, scans a node's stored edge row in the scan and find states, and each time
// a child returns it pops, resumes and scans the row again, paced by the single edge-row
// memory port. A reported cycle then passes the emit and emit-wait states for each stack
// entry, plus any output stall. A two-entry command queue lets new beats be taken while a
// search runs; results are held in an output register until taken.
module rag_deadlock_cycle_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       stall,
	input  logic [1:0] command,
	input  logic       edge_kind,
	input  logic [4:0] from_number,
	input  logic [4:0] to_number,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       deadlock,
	output logic       node_is_resource,
	output logic [4:0] node_number,
	output logic       last,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data
);
	import rag_pkg::*;

	logic [CountW-1:0] num_processes_q, num_resources_q;
	logic job_valid, job_ready;
	job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_processes_q <= saturate_count(CountW'(32), MaxProcesses);
			num_resources_q <= saturate_count(CountW'(32), MaxResources);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_NUM_PROCESSES: num_processes_q <= saturate_count(cfg_data, MaxProcesses);
				REG_NUM_RESOURCES: num_resources_q <= saturate_count(cfg_data, MaxResources);
				default: ;
			endcase
		end
	end

	rag_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .command(command),
		.edge_kind(edge_kind), .from_number(from_number), .to_number(to_number),
		.num_processes(num_processes_q), .num_resources(num_resources_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	rag_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready), .job(job),
		.num_processes(num_processes_q), .num_resources(num_resources_q),
		.out_valid(out_valid), .out_stall(out_stall), .deadlock(deadlock),
		.node_is_resource(node_is_resource), .node_number(node_number), .last(last)
	);

endmodule
